### hw/rtl/sxl_pkg.sv
// shared constants, codes and control structs for the s-expression lexer
`timescale 1ns / 1ps
`default_nettype none

package sxl_pkg;

  localparam int WORD_BUFFER = 16;
  localparam int KEEP_MAX    = WORD_BUFFER - 1;
  localparam int LEN_W       = $clog2(WORD_BUFFER);
  localparam int IDX_W       = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_INT   = 3'd2,
    KIND_SYM   = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CLS_WORD  = 2'd0,
    CLS_SPACE = 2'd1,
    CLS_TOKEN = 2'd2
  } char_cls_t;

  typedef enum logic [1:0] {
    OSEL_INT   = 2'd0,
    OSEL_SYM   = 2'd1,
    OSEL_TOKEN = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic     append;
    logic     latch_delim;
    logic     load_out;
    out_sel_t out_sel;
    logic     out_last;
    logic     emit_step;
    logic     word_clear;
  } cmd_t;

  typedef struct packed {
    char_cls_t cls;
    logic      word_empty;
    logic      word_numeric;
    logic      sym_last;
    logic      pend_space;
    logic      slot_free;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/sxl_ifs.sv
// valid/ready channel interfaces for characters in and tokens out
`timescale 1ns / 1ps
`default_nettype none

interface sxl_char_if;
  logic                          valid;
  logic                          ready;
  logic [sxl_pkg::CHAR_W-1:0]    char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface sxl_tok_if;
  logic                          valid;
  logic                          ready;
  logic [sxl_pkg::KIND_W-1:0]    token_kind;
  logic signed [sxl_pkg::VALUE_W-1:0] int_value;
  logic [sxl_pkg::CHAR_W-1:0]    symbol_char;
  logic                          last_of_run;

  modport source (output valid, output token_kind, output int_value, output symbol_char,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_value, input symbol_char,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/sxl_ctrl.sv
// lexer controller: sequences word flushes and token transfers
`timescale 1ns / 1ps
`default_nettype none

module sxl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sxl_pkg::status_t sts,
  output sxl_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYM_RD,
    S_SYM_WR,
    S_INT,
    S_TOKEN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid && in_ready_r;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.out_sel     = sxl_pkg::OSEL_TOKEN;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.cls == sxl_pkg::CLS_WORD) begin
            cmd.append = 1'b1;
          end else begin
            cmd.latch_delim = 1'b1;
            if (!sts.word_empty) begin
              state_nxt = sts.word_numeric ? S_INT : S_SYM_RD;
            end else if (sts.cls == sxl_pkg::CLS_TOKEN) begin
              state_nxt = S_TOKEN;
            end
          end
        end
      end
      // buffer read data is registered, so each character gets a read state before its write state
      S_SYM_RD: begin
        state_nxt = S_SYM_WR;
      end
      S_SYM_WR: begin
        if (sts.slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_sel   = sxl_pkg::OSEL_SYM;
          cmd.out_last  = sts.sym_last && sts.pend_space;
          cmd.emit_step = 1'b1;
          if (sts.sym_last) begin
            cmd.word_clear = 1'b1;
            state_nxt      = sts.pend_space ? S_IDLE : S_TOKEN;
          end else begin
            state_nxt = S_SYM_RD;
          end
        end
      end
      S_INT: begin
        if (sts.slot_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_sel    = sxl_pkg::OSEL_INT;
          cmd.out_last   = sts.pend_space;
          cmd.word_clear = 1'b1;
          state_nxt      = sts.pend_space ? S_IDLE : S_TOKEN;
        end
      end
      S_TOKEN: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = sxl_pkg::OSEL_TOKEN;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sxl_dpath.sv
// lexer datapath: word buffer, running integer value and output register
`timescale 1ns / 1ps
`default_nettype none

module sxl_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [sxl_pkg::CHAR_W-1:0]    char_in,
  input  wire sxl_pkg::cmd_t                 cmd,
  output sxl_pkg::status_t                   sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sxl_pkg::KIND_W-1:0]         token_kind,
  output logic signed [sxl_pkg::VALUE_W-1:0] int_value,
  output logic [sxl_pkg::CHAR_W-1:0]         symbol_char,
  output logic                               last_of_run
);

  logic [sxl_pkg::CHAR_W-1:0]  word_mem [sxl_pkg::KEEP_MAX];
  logic [sxl_pkg::CHAR_W-1:0]  rd_data_r;
  logic [sxl_pkg::LEN_W-1:0]   len_r;
  logic [sxl_pkg::LEN_W-1:0]   emit_pos_r;
  logic [sxl_pkg::VALUE_W-1:0] acc_r;
  logic                        neg_r;
  logic                        num_ok_r;
  logic                        has_digit_r;
  logic [sxl_pkg::KIND_W-1:0]  pend_kind_r;
  logic                        pend_space_r;

  logic                        out_valid_r;
  logic [sxl_pkg::KIND_W-1:0]  kind_r;
  logic [sxl_pkg::VALUE_W-1:0] value_r;
  logic [sxl_pkg::CHAR_W-1:0]  sym_r;
  logic                        last_r;

  logic                        full;
  logic                        is_digit;
  logic [sxl_pkg::VALUE_W-1:0] digit_ext;
  logic [sxl_pkg::VALUE_W-1:0] acc_times10;
  logic [sxl_pkg::KIND_W-1:0]  delim_kind;

  assign full        = (len_r == sxl_pkg::LEN_W'(sxl_pkg::KEEP_MAX));
  assign is_digit    = (char_in >= sxl_pkg::CH_ZERO) && (char_in <= sxl_pkg::CH_NINE);
  // ascii digits carry their value in the low nibble
  assign digit_ext   = sxl_pkg::VALUE_W'(char_in[3:0]);
  assign acc_times10 = (acc_r << 3) + (acc_r << 1);

  always_comb begin
    sts.word_empty   = (len_r == '0);
    sts.word_numeric = num_ok_r && has_digit_r;
    sts.sym_last     = (sxl_pkg::LEN_W'(emit_pos_r + 1'b1) == len_r);
    sts.pend_space   = pend_space_r;
    sts.slot_free    = !out_valid_r || out_ready;
    unique case (char_in)
      sxl_pkg::CH_SPACE, sxl_pkg::CH_TAB, sxl_pkg::CH_CR, sxl_pkg::CH_LF:
        sts.cls = sxl_pkg::CLS_SPACE;
      sxl_pkg::CH_OPEN, sxl_pkg::CH_CLOSE, sxl_pkg::CH_NUL:
        sts.cls = sxl_pkg::CLS_TOKEN;
      default:
        sts.cls = sxl_pkg::CLS_WORD;
    endcase
  end

  always_comb begin
    unique case (char_in)
      sxl_pkg::CH_OPEN:  delim_kind = sxl_pkg::KIND_OPEN;
      sxl_pkg::CH_CLOSE: delim_kind = sxl_pkg::KIND_CLOSE;
      default:           delim_kind = sxl_pkg::KIND_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      word_mem[len_r[sxl_pkg::IDX_W-1:0]] <= char_in;
    end
    rd_data_r <= word_mem[emit_pos_r[sxl_pkg::IDX_W-1:0]];
  end

  // integer value is built as characters arrive
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      if (len_r == '0) begin
        neg_r       <= (char_in == sxl_pkg::CH_MINUS);
        num_ok_r    <= (char_in == sxl_pkg::CH_MINUS) || is_digit;
        has_digit_r <= is_digit;
        acc_r       <= is_digit ? digit_ext : '0;
      end else if (is_digit) begin
        has_digit_r <= 1'b1;
        acc_r       <= acc_times10 + digit_ext;
      end else begin
        num_ok_r <= 1'b0;
      end
    end
    if (cmd.latch_delim) begin
      pend_kind_r  <= delim_kind;
      pend_space_r <= (sts.cls == sxl_pkg::CLS_SPACE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      emit_pos_r <= '0;
    end else begin
      if (cmd.word_clear) begin
        len_r      <= '0;
        emit_pos_r <= '0;
      end else begin
        if (cmd.append && !full) begin
          len_r <= sxl_pkg::LEN_W'(len_r + 1'b1);
        end
        if (cmd.emit_step) begin
          emit_pos_r <= sxl_pkg::LEN_W'(emit_pos_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      last_r <= cmd.out_last;
      case (cmd.out_sel)
        sxl_pkg::OSEL_INT: begin
          kind_r  <= sxl_pkg::KIND_INT;
          value_r <= neg_r ? (sxl_pkg::VALUE_W'(0) - acc_r) : acc_r;
          sym_r   <= '0;
        end
        sxl_pkg::OSEL_SYM: begin
          kind_r  <= sxl_pkg::KIND_SYM;
          value_r <= '0;
          sym_r   <= rd_data_r;
        end
        default: begin
          kind_r  <= pend_kind_r;
          value_r <= '0;
          sym_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign token_kind  = kind_r;
  assign int_value   = value_r;
  assign symbol_char = sym_r;
  assign last_of_run = last_r;

endmodule

`default_nettype wire

### hw/rtl/sexpr_token_lexer_core.sv
// s-expression lexer top level: controller, datapath and channel wiring
`timescale 1ns / 1ps
`default_nettype none

// Takes one character per transfer and returns tokens: parentheses, end of
// input (byte 0), integers (optional minus and decimal digits, wrapping
// modulo 2^32) and symbols, sent as one transfer per kept character (first
// 15 kept). last_of_run marks the final token caused by one character. A
// word character does not stall the input. A delimiter is taken, after
// which the input stays stalled while the pending word drains: the S_INT
// state for an integer, a read and a write state per symbol character (the
// word buffer has one registered read port), the S_TOKEN state for a
// parenthesis or end token, plus any output stall. A finished token waits
// in the output register while the next character is taken.
module sexpr_token_lexer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sxl_char_if.sink  in_if,
  sxl_tok_if.source out_if
);

  sxl_pkg::cmd_t    cmd;
  sxl_pkg::status_t sts;

  sxl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sxl_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_in     (in_if.char_in),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .token_kind  (out_if.token_kind),
    .int_value   (out_if.int_value),
    .symbol_char (out_if.symbol_char),
    .last_of_run (out_if.last_of_run)
  );

endmodule

`default_nettype wire
